// ----- rtl/core/dual_priority_ring_queue_unit_assert.svh -----
// Assertion macros for the dual priority ring queue unit.
`ifndef DUAL_PRIORITY_RING_QUEUE_UNIT_ASSERT_SVH
`define DUAL_PRIORITY_RING_QUEUE_UNIT_ASSERT_SVH

// same-cycle implication
`define DPQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dpq assertion failed");

// next-cycle implication
`define DPQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dpq assertion failed");

`endif

// ----- rtl/core/dpq_pkg.sv -----
// Package: types, constants and helpers for the dual priority ring queue unit.
package dpq_pkg;

  localparam int NUM_QUEUES  = 4;
  localparam int QW          = $clog2(NUM_QUEUES);
  localparam int RING_DEPTH  = 16;
  localparam int PW          = $clog2(RING_DEPTH);
  localparam int DW          = 5;
  localparam int ENTRY_WIDTH = 32;
  localparam int AW          = QW + PW;
  localparam int MEM_DEPTH   = NUM_QUEUES * RING_DEPTH;

  localparam logic [3:0]    STARVE_PERIOD = 4'd10;
  localparam logic [DW-1:0] DEPTH_MAX     = DW'(RING_DEPTH);
  localparam logic [DW-1:0] DEPTH_MIN     = DW'(1);

  typedef enum logic [2:0] {
    OP_ADD_LOW  = 3'd0,
    OP_ADD_HIGH = 3'd1,
    OP_GET      = 3'd2,
    OP_PEEK     = 3'd3,
    OP_CLEAR    = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    FILL_EMPTY  = 2'd0,
    FILL_NORMAL = 2'd1,
    FILL_FULL   = 2'd2
  } fill_t;

  typedef struct packed {
    logic [2:0]             op;
    logic [QW-1:0]          queue_index;
    logic [ENTRY_WIDTH-1:0] entry_value;
  } req_t;

  typedef struct packed {
    status_t                status;
    logic [ENTRY_WIDTH-1:0] out_value;
    logic                   from_high;
  } rsp_t;

  // per-cycle command to one ring bank
  typedef struct packed {
    logic          add;
    logic          take;
    logic          clr;
    logic [QW-1:0] q;
  } ring_cmd_t;

  function automatic logic [PW-1:0] ring_adv(logic [PW-1:0] p, logic [DW-1:0] d);
    logic [DW-1:0] n;
    n = DW'(p) + DW'(1);
    return (n >= d) ? '0 : n[PW-1:0];
  endfunction

endpackage

// ----- rtl/core/dpq_ring_bank.sv -----
// One bank of rings (one per queue): slot memory, pointers and fill state.
module dpq_ring_bank (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  dpq_pkg::ring_cmd_t                       cmd,
  input  logic [dpq_pkg::ENTRY_WIDTH-1:0]          wdata,
  input  logic [dpq_pkg::DW-1:0]                   depth,
  output dpq_pkg::fill_t [dpq_pkg::NUM_QUEUES-1:0] fill,
  output logic [dpq_pkg::ENTRY_WIDTH-1:0]          rd_data
);

  logic [dpq_pkg::ENTRY_WIDTH-1:0] mem [dpq_pkg::MEM_DEPTH];

  logic [dpq_pkg::PW-1:0] wr_r  [dpq_pkg::NUM_QUEUES];
  logic [dpq_pkg::PW-1:0] wr_nxt[dpq_pkg::NUM_QUEUES];
  logic [dpq_pkg::PW-1:0] rd_r  [dpq_pkg::NUM_QUEUES];
  logic [dpq_pkg::PW-1:0] rd_nxt[dpq_pkg::NUM_QUEUES];
  dpq_pkg::fill_t         fill_r  [dpq_pkg::NUM_QUEUES];
  dpq_pkg::fill_t         fill_nxt[dpq_pkg::NUM_QUEUES];

  logic [dpq_pkg::PW-1:0] wr_cur;
  logic [dpq_pkg::PW-1:0] rd_cur;
  logic [dpq_pkg::PW-1:0] wr_adv;
  logic [dpq_pkg::PW-1:0] rd_adv;

  assign wr_cur = wr_r[cmd.q];
  assign rd_cur = rd_r[cmd.q];
  assign wr_adv = dpq_pkg::ring_adv(wr_cur, depth);
  assign rd_adv = dpq_pkg::ring_adv(rd_cur, depth);

  always_comb begin
    for (int i = 0; i < dpq_pkg::NUM_QUEUES; i++) begin
      wr_nxt[i]   = wr_r[i];
      rd_nxt[i]   = rd_r[i];
      fill_nxt[i] = fill_r[i];
      if (cmd.q == dpq_pkg::QW'(i)) begin
        if (cmd.clr) begin
          wr_nxt[i]   = '0;
          rd_nxt[i]   = '0;
          fill_nxt[i] = dpq_pkg::FILL_EMPTY;
        end else if (cmd.add) begin
          wr_nxt[i]   = wr_adv;
          fill_nxt[i] = (wr_adv == rd_r[i]) ? dpq_pkg::FILL_FULL : dpq_pkg::FILL_NORMAL;
        end else if (cmd.take) begin
          rd_nxt[i]   = rd_adv;
          fill_nxt[i] = (rd_adv == wr_r[i]) ? dpq_pkg::FILL_EMPTY : dpq_pkg::FILL_NORMAL;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < dpq_pkg::NUM_QUEUES; i++) begin
        wr_r[i]   <= '0;
        rd_r[i]   <= '0;
        fill_r[i] <= dpq_pkg::FILL_EMPTY;
      end
    end else begin
      for (int i = 0; i < dpq_pkg::NUM_QUEUES; i++) begin
        wr_r[i]   <= wr_nxt[i];
        rd_r[i]   <= rd_nxt[i];
        fill_r[i] <= fill_nxt[i];
      end
    end
  end

  // slot memory: one write, one registered read at the addressed queue's head
  always_ff @(posedge clk) begin
    if (cmd.add) begin
      mem[{cmd.q, wr_cur}] <= wdata;
    end
    rd_data <= mem[{cmd.q, rd_cur}];
  end

  always_comb begin
    for (int i = 0; i < dpq_pkg::NUM_QUEUES; i++) begin
      fill[i] = fill_r[i];
    end
  end

endmodule

// ----- rtl/core/dual_priority_ring_queue_unit.sv -----
// Top level: two-level priority ring queues with a shared starvation counter.
//
//   channel | ports                              | handshake
//   --------+------------------------------------+-----------------------------
//   input   | start, busy, in_req                | taken when start && !busy
//   result  | out_strobe, out_rsp                | one cycle, cannot be held off
//   config  | cfg_valid, cfg_ready, cfg_data     | written when valid && ready
//
// One request per cycle; each result passes through the input register and then the registered
// slot read (with the status registered alongside it).
// busy and cfg_ready are constant; nothing ever stalls.
// Synchronous active-low reset empties every ring, zeroes the counter, depth 16.
module dual_priority_ring_queue_unit (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  dpq_pkg::req_t          in_req,
  output logic                   out_strobe,
  output dpq_pkg::rsp_t          out_rsp,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [dpq_pkg::DW-1:0] cfg_data
);

  logic                          s1_valid_r;
  dpq_pkg::req_t                 s1_req_r;
  logic [dpq_pkg::DW-1:0]        depth_r;
  logic [3:0]                    cnt_r;
  logic [3:0]                    cnt_nxt;
  logic [3:0]                    cnt_inc;

  logic                          out_strobe_r;
  dpq_pkg::status_t              status_r;
  dpq_pkg::status_t              status_nxt;
  logic                          from_high_r;
  logic                          from_high_nxt;
  logic                          ret_r;
  logic                          ret_nxt;

  dpq_pkg::ring_cmd_t                       lo_cmd;
  dpq_pkg::ring_cmd_t                       hi_cmd;
  dpq_pkg::fill_t [dpq_pkg::NUM_QUEUES-1:0] lo_fill;
  dpq_pkg::fill_t [dpq_pkg::NUM_QUEUES-1:0] hi_fill;
  logic [dpq_pkg::ENTRY_WIDTH-1:0]          lo_data;
  logic [dpq_pkg::ENTRY_WIDTH-1:0]          hi_data;
  dpq_pkg::fill_t                           lo_f;
  dpq_pkg::fill_t                           hi_f;
  logic                                     prefer_low;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  assign lo_f = lo_fill[s1_req_r.queue_index];
  assign hi_f = hi_fill[s1_req_r.queue_index];
  assign cnt_inc    = cnt_r + 4'd1;
  assign prefer_low = (cnt_inc == dpq_pkg::STARVE_PERIOD);

  always_comb begin
    lo_cmd        = '{add: 1'b0, take: 1'b0, clr: 1'b0, q: s1_req_r.queue_index};
    hi_cmd        = '{add: 1'b0, take: 1'b0, clr: 1'b0, q: s1_req_r.queue_index};
    status_nxt    = dpq_pkg::ST_OK;
    from_high_nxt = 1'b0;
    ret_nxt       = 1'b0;
    cnt_nxt       = cnt_r;
    if (s1_valid_r) begin
      case (s1_req_r.op)
        dpq_pkg::OP_ADD_LOW: begin
          if (lo_f == dpq_pkg::FILL_FULL) status_nxt = dpq_pkg::ST_FULL;
          else lo_cmd.add = 1'b1;
        end
        dpq_pkg::OP_ADD_HIGH: begin
          if (hi_f == dpq_pkg::FILL_FULL) status_nxt = dpq_pkg::ST_FULL;
          else hi_cmd.add = 1'b1;
        end
        dpq_pkg::OP_GET: begin
          if (lo_f == dpq_pkg::FILL_EMPTY && hi_f == dpq_pkg::FILL_EMPTY) begin
            status_nxt = dpq_pkg::ST_EMPTY;
          end else begin
            cnt_nxt = prefer_low ? 4'd0 : cnt_inc;
            ret_nxt = 1'b1;
            // every tenth served get goes to the low ring if it has anything
            if (prefer_low ? (lo_f == dpq_pkg::FILL_EMPTY) : (hi_f != dpq_pkg::FILL_EMPTY)) begin
              hi_cmd.take   = 1'b1;
              from_high_nxt = 1'b1;
            end else begin
              lo_cmd.take = 1'b1;
            end
          end
        end
        dpq_pkg::OP_PEEK: begin
          if (hi_f != dpq_pkg::FILL_EMPTY) begin
            ret_nxt       = 1'b1;
            from_high_nxt = 1'b1;
          end else if (lo_f != dpq_pkg::FILL_EMPTY) begin
            ret_nxt = 1'b1;
          end else begin
            status_nxt = dpq_pkg::ST_EMPTY;
          end
        end
        dpq_pkg::OP_CLEAR: begin
          lo_cmd.clr = 1'b1;
          hi_cmd.clr = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_strobe_r <= 1'b0;
      cnt_r        <= '0;
      depth_r      <= dpq_pkg::DEPTH_MAX;
    end else begin
      s1_valid_r   <= start && !busy;
      out_strobe_r <= s1_valid_r;
      cnt_r        <= cnt_nxt;
      // store the depth already clamped to the usable range
      if (cfg_valid && cfg_ready) begin
        if (cfg_data < dpq_pkg::DEPTH_MIN)      depth_r <= dpq_pkg::DEPTH_MIN;
        else if (cfg_data > dpq_pkg::DEPTH_MAX) depth_r <= dpq_pkg::DEPTH_MAX;
        else                                    depth_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) s1_req_r <= in_req;
    status_r    <= status_nxt;
    from_high_r <= from_high_nxt;
    ret_r       <= ret_nxt;
  end

  dpq_ring_bank u_low (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (lo_cmd),
    .wdata  (s1_req_r.entry_value),
    .depth  (depth_r),
    .fill   (lo_fill),
    .rd_data(lo_data)
  );

  dpq_ring_bank u_high (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (hi_cmd),
    .wdata  (s1_req_r.entry_value),
    .depth  (depth_r),
    .fill   (hi_fill),
    .rd_data(hi_data)
  );

  assign out_strobe        = out_strobe_r;
  assign out_rsp.status    = status_r;
  assign out_rsp.from_high = from_high_r;
  assign out_rsp.out_value = !ret_r ? '0 : (from_high_r ? hi_data : lo_data);

endmodule

// ----- rtl/core/dpq_checker.sv -----
// Port-level checker for the dual priority ring queue unit, with its bind.
`include "dual_priority_ring_queue_unit_assert.svh"

module dpq_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input logic          out_strobe,
  input dpq_pkg::rsp_t out_rsp
);

  // a taken request shows its result after the s1 valid and output strobe registers, and only then
  `DPQ_ASSERT_NEXT(a_result_follows, $past(start && !busy && rst_n), out_strobe)
  `DPQ_ASSERT_NEXT(a_no_spurious, !$past(start && !busy && rst_n), !out_strobe)
  `DPQ_ASSERT_NOW(a_fail_no_entry, out_strobe && out_rsp.status != dpq_pkg::ST_OK, out_rsp.out_value == '0 && !out_rsp.from_high)
  `DPQ_ASSERT_NOW(a_high_is_ok, out_strobe && out_rsp.from_high, out_rsp.status == dpq_pkg::ST_OK)

endmodule

bind dual_priority_ring_queue_unit dpq_checker u_dpq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_strobe(out_strobe),
  .out_rsp   (out_rsp)
);

// ----- test/dual_priority_ring_queue_unit_tb.sv -----
// Self-checking testbench for the dual priority ring queue unit: directed and random requests.
module dual_priority_ring_queue_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dpq_pkg::*;

  localparam int LOW_RING = 0;
  localparam int HIGH_RING = 1;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS = 75;
  localparam int BLOCK_ITEMS = 25;
  localparam logic [2:0] OP_UNKNOWN_LO = 3'd5;
  localparam logic [2:0] OP_UNKNOWN_HI = 3'd7;

  // Mirror of the queue engine plus the list of responses still owed by the block.
  class queue_engine_mirror;
    logic [ENTRY_WIDTH-1:0] slot [2][NUM_QUEUES][RING_DEPTH];
    bit written [2][NUM_QUEUES][RING_DEPTH];
    int unsigned wr_ptr [2][NUM_QUEUES];
    int unsigned rd_ptr [2][NUM_QUEUES];
    fill_t fill [2][NUM_QUEUES];
    logic [3:0] get_count;
    logic [DW-1:0] depth;
    rsp_t due_responses [$];
    int errors;

    function new();
      for (int b = 0; b < 2; b++) begin
        for (int q = 0; q < NUM_QUEUES; q++) begin
          wr_ptr[b][q] = 0;
          rd_ptr[b][q] = 0;
          fill[b][q] = FILL_EMPTY;
          for (int s = 0; s < RING_DEPTH; s++) written[b][q][s] = 1'b0;
        end
      end
      get_count = '0;
      depth = DEPTH_MAX;
      errors = 0;
    endfunction

    function int unsigned next_ptr(int unsigned p);
      int unsigned lim;
      int unsigned n;
      lim = (depth < DEPTH_MIN) ? DEPTH_MIN : (depth > DEPTH_MAX) ? DEPTH_MAX : depth;
      n = p + 1;
      return (n >= lim) ? 0 : n;
    endfunction

    // ring a get or peek would read from, -1 when the queue is empty
    function int source_ring(logic [2:0] op, int unsigned q);
      logic [3:0] nxt;
      if (fill[LOW_RING][q] == FILL_EMPTY && fill[HIGH_RING][q] == FILL_EMPTY) return -1;
      if (op == OP_GET) begin
        nxt = get_count + 4'd1;
        if (nxt == STARVE_PERIOD) return (fill[LOW_RING][q] == FILL_EMPTY) ? HIGH_RING : LOW_RING;
      end
      return (fill[HIGH_RING][q] != FILL_EMPTY) ? HIGH_RING : LOW_RING;
    endfunction

    // stale pointers after a depth change may land on a slot never written
    function req_t avoid_blank_read(req_t r);
      int b;
      if (r.op == OP_GET || r.op == OP_PEEK) begin
        b = source_ring(r.op, r.queue_index);
        if (b >= 0 && !written[b][r.queue_index][rd_ptr[b][r.queue_index]]) r.op = OP_CLEAR;
      end
      return r;
    endfunction

    function rsp_t serve(req_t r);
      rsp_t rsp;
      int b;
      int unsigned q;
      rsp = '0;
      rsp.status = ST_OK;
      q = r.queue_index;
      case (r.op)
        OP_ADD_LOW, OP_ADD_HIGH: begin
          b = (r.op == OP_ADD_HIGH) ? HIGH_RING : LOW_RING;
          if (fill[b][q] == FILL_FULL) begin
            rsp.status = ST_FULL;
          end else begin
            slot[b][q][wr_ptr[b][q]] = r.entry_value;
            written[b][q][wr_ptr[b][q]] = 1'b1;
            wr_ptr[b][q] = next_ptr(wr_ptr[b][q]);
            fill[b][q] = (wr_ptr[b][q] == rd_ptr[b][q]) ? FILL_FULL : FILL_NORMAL;
          end
        end
        OP_GET: begin
          b = source_ring(r.op, q);
          if (b < 0) begin
            rsp.status = ST_EMPTY;
          end else begin
            get_count = get_count + 4'd1;
            if (get_count == STARVE_PERIOD) get_count = '0;
            rsp.out_value = slot[b][q][rd_ptr[b][q]];
            rsp.from_high = (b == HIGH_RING);
            rd_ptr[b][q] = next_ptr(rd_ptr[b][q]);
            fill[b][q] = (rd_ptr[b][q] == wr_ptr[b][q]) ? FILL_EMPTY : FILL_NORMAL;
          end
        end
        OP_PEEK: begin
          b = source_ring(r.op, q);
          if (b < 0) begin
            rsp.status = ST_EMPTY;
          end else begin
            rsp.out_value = slot[b][q][rd_ptr[b][q]];
            rsp.from_high = (b == HIGH_RING);
          end
        end
        OP_CLEAR: begin
          for (int k = 0; k < 2; k++) begin
            wr_ptr[k][q] = 0;
            rd_ptr[k][q] = 0;
            fill[k][q] = FILL_EMPTY;
          end
        end
        default: ;
      endcase
      return rsp;
    endfunction

    function void note_request(req_t r);
      due_responses.push_back(serve(r));
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      if (due_responses.size() == 0) begin
        $display("%0t: result with no request outstanding: status %0d value %h high %b",
                 $time, got.status, got.out_value, got.from_high);
        errors++;
        return;
      end
      want = due_responses.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status mismatch: expected %0d, actual %0d", $time, want.status,
                 got.status);
        errors++;
      end
      if (got.out_value !== want.out_value) begin
        $display("%0t: out_value mismatch: expected %h, actual %h", $time, want.out_value,
                 got.out_value);
        errors++;
      end
      if (got.from_high !== want.from_high) begin
        $display("%0t: from_high mismatch: expected %b, actual %b", $time, want.from_high,
                 got.from_high);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  req_t in_req;
  logic out_strobe;
  rsp_t out_rsp;
  logic cfg_valid;
  logic cfg_ready;
  logic [DW-1:0] cfg_data;

  queue_engine_mirror sb;
  int idle_cycles;

  dual_priority_ring_queue_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_strobe(out_strobe),
    .out_rsp   (out_rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe !== 1'b0) sb.check_result(out_rsp);
  end

  initial idle_cycles = 0;

  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("dual_priority_ring_queue_unit_tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic req_t make_request(logic [2:0] op, int unsigned q, logic [31:0] v);
    req_t r;
    r.op = op;
    r.queue_index = q[QW-1:0];
    r.entry_value = v;
    return r;
  endfunction

  function automatic int unsigned pick_gap(bit idle_on);
    int unsigned w;
    if (!idle_on) return 0;
    w = $urandom_range(0, 99);
    if (w < 60) return 0;
    if (w < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic req_t random_request(int unsigned hot_q, int hot_ring, bit filling);
    int unsigned w;
    int unsigned q;
    int unsigned add_end;
    logic [2:0] op;
    w = $urandom_range(0, 99);
    q = ($urandom_range(0, 99) < 85) ? hot_q : $urandom_range(0, NUM_QUEUES - 1);
    add_end = filling ? 70 : 25;
    if (w < add_end) begin
      if ($urandom_range(0, 99) < 85) op = (hot_ring == HIGH_RING) ? OP_ADD_HIGH : OP_ADD_LOW;
      else op = (hot_ring == HIGH_RING) ? OP_ADD_LOW : OP_ADD_HIGH;
    end else if (w < 85) begin
      op = OP_GET;
    end else if (w < 93) begin
      op = OP_PEEK;
    end else if (w < 95) begin
      op = OP_CLEAR;
    end else begin
      op = 3'($urandom_range(OP_UNKNOWN_LO, OP_UNKNOWN_HI));
    end
    return make_request(op, q, $urandom);
  endfunction

  // called at a falling edge; returns at the falling edge after the request is taken
  task automatic issue(req_t r, int unsigned gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    r = sb.avoid_blank_read(r);
    start <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (busy);
    sb.note_request(r);
    @(negedge clk);
  endtask

  task automatic write_depth(logic [DW-1:0] d);
    start <= 1'b0;
    while (sb.due_responses.size() != 0) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    sb.depth = d;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [DW-1:0] depths [7];
    logic [DW-1:0] d;
    int unsigned hot_q;
    int hot_ring;
    bit filling;
    bit idle_on;

    sb = new();
    depths = '{5'd2, 5'd16, 5'd0, 5'd31, 5'd5, 5'd17, 5'd4};
    rst_n = 1'b0;
    start = 1'b0;
    in_req = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed, reset depth
    issue(make_request(OP_GET, 0, 32'h0), 0);
    issue(make_request(OP_PEEK, 1, 32'h0), 0);
    issue(make_request(OP_ADD_LOW, 0, 32'h0000_0000), 0);
    issue(make_request(OP_ADD_HIGH, 0, 32'hFFFF_FFFF), 1);
    issue(make_request(OP_PEEK, 0, 32'h0), 0);
    issue(make_request(OP_GET, 0, 32'h0), 0);
    issue(make_request(OP_PEEK, 0, 32'h0), 2);
    issue(make_request(OP_GET, 0, 32'h0), 0);
    issue(make_request(OP_GET, 0, 32'h0), 0);
    issue(make_request(OP_ADD_HIGH, 3, 32'hA5A5_A5A5), 0);
    issue(make_request(OP_ADD_LOW, 3, 32'h5A5A_5A5A), 0);
    issue(make_request(OP_CLEAR, 3, 32'h0), 0);
    issue(make_request(OP_PEEK, 3, 32'h0), 0);
    issue(make_request(OP_UNKNOWN_LO, 2, 32'hFFFF_FFFF), 0);
    issue(make_request(OP_UNKNOWN_HI, 1, 32'hFFFF_FFFF), 0);

    // directed, single-slot rings: full on second add
    write_depth(5'd1);
    issue(make_request(OP_ADD_LOW, 1, 32'h1234_5678), 0);
    issue(make_request(OP_ADD_LOW, 1, 32'hDEAD_BEEF), 0);
    issue(make_request(OP_ADD_HIGH, 1, 32'h8765_4321), 0);
    issue(make_request(OP_ADD_HIGH, 1, 32'hCAFE_F00D), 0);
    issue(make_request(OP_GET, 1, 32'h0), 0);
    issue(make_request(OP_GET, 1, 32'h0), 0);
    issue(make_request(OP_GET, 1, 32'h0), 0);
    issue(make_request(OP_CLEAR, 0, 32'h0), 0);

    for (int p = 0; p < 8; p++) begin
      d = (p == 7) ? DW'($urandom_range(0, 31)) : depths[p];
      write_depth(d);
      hot_q = $urandom_range(0, NUM_QUEUES - 1);
      filling = 1'b1;
      idle_on = 1'b1;
      hot_ring = LOW_RING;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % BLOCK_ITEMS == 0) begin
          filling = (i == 0) ? 1'b1 : 1'($urandom_range(0, 1));
          idle_on = ($urandom_range(0, 3) != 0);
          hot_ring = $urandom_range(0, 1) ? HIGH_RING : LOW_RING;
        end
        issue(random_request(hot_q, hot_ring, filling), pick_gap(idle_on));
      end
    end

    start <= 1'b0;
    while (sb.due_responses.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.errors == 0 && sb.due_responses.size() == 0) begin
      $display("dual_priority_ring_queue_unit_tb OK");
    end else begin
      $display("dual_priority_ring_queue_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/dpq_pkg.sv
rtl/core/dpq_ring_bank.sv
rtl/core/dual_priority_ring_queue_unit.sv
rtl/core/dpq_checker.sv
test/dual_priority_ring_queue_unit_tb.sv
